@@ design/cvds_pkg.sv @@
package cvds_pkg;

  // Linear-light precision and coefficient format
  localparam int LINEAR_FRAC_BITS_DEF = 16;
  localparam int COEF_FRAC = 14;
  localparam int COEF_W = 16;
  localparam int CODE_W = 8;
  localparam int CODES = 256;
  localparam int CHANNELS = 3;
  localparam int MAT_ENTRIES = 9;

  // Configuration port
  localparam int SEV_W = 9;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_INDEX_W = 1;
  localparam logic [SEV_W-1:0] SEV_FULL = 9'd256;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DEFICIENCY_TYPE = 1'b0,
    REG_SEVERITY        = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CVD_NORMAL = 2'd0,
    CVD_PROTAN = 2'd1,
    CVD_DEUTAN = 2'd2,
    CVD_TRITAN = 2'd3
  } cvd_type_t;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t [MAT_ENTRIES-1:0] coef_mat_t;

  // Pixel payloads
  typedef struct packed {
    logic [CODE_W-1:0] in_red;
    logic [CODE_W-1:0] in_green;
    logic [CODE_W-1:0] in_blue;
  } in_pixel_t;

  typedef struct packed {
    logic [CODE_W-1:0] out_red;
    logic [CODE_W-1:0] out_green;
    logic [CODE_W-1:0] out_blue;
  } out_pixel_t;

  // Stage load strobes, one per pipeline register
  typedef struct packed {
    logic ld_lin;
    logic ld_prod;
    logic ld_sum;
    logic ld_therm;
    logic ld_out;
  } pipe_ctl_t;

  localparam coef_t COEF_ONE = 16'sd16384;

  localparam coef_mat_t IDENT_MAT = {
    COEF_ONE, 16'sd0, 16'sd0,
    16'sd0, COEF_ONE, 16'sd0,
    16'sd0, 16'sd0, COEF_ONE
  };

  // Full dichromacy matrices in linear RGB, row major, Q2.14
  localparam coef_t TARGET_Q [4][MAT_ENTRIES] = '{
    '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384},
    '{16'sd2495, 16'sd17246, -16'sd3357, 16'sd1876, 16'sd12882, 16'sd1626,
      -16'sd64, -16'sd788, 16'sd17236},
    '{16'sd6018, 16'sd14101, -16'sd3735, 16'sd4589, 16'sd11018, 16'sd777,
      -16'sd194, 16'sd704, 16'sd15874},
    '{16'sd20571, -16'sd1257, -16'sd2929, -16'sd1285, 16'sd15250, 16'sd2418,
      16'sd78, 16'sd11327, 16'sd4979}
  };

  // u^5 * 255^11, exact
  function automatic logic [255:0] pow_lhs(input logic [31:0] u);
    logic [255:0] acc;
    acc = 256'd1;
    for (int i = 0; i < 5; i++) acc = acc * 256'(u);
    for (int i = 0; i < 11; i++) acc = acc * 256'd255;
    return acc;
  endfunction

  // Smallest T with T / 2^frac_bits >= (code / 255)^2.2, exact integer search
  function automatic logic [31:0] lin_entry(input int frac_bits, input int code);
    logic [255:0] rhs;
    logic [255:0] lhs;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] mid;
    rhs = 256'd1;
    for (int i = 0; i < 11; i++) rhs = rhs * 256'(code);
    rhs = rhs << (5 * frac_bits);
    lo = 32'd0;
    hi = 32'd1 << frac_bits;
    for (int j = 0; j < 32; j++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo + 32'd1) >> 1);
        lhs = pow_lhs(mid);
        if (lhs <= rhs) begin
          lo = mid;
        end else begin
          hi = mid - 32'd1;
        end
      end
    end
    lhs = pow_lhs(lo);
    return (lhs == rhs) ? lo : lo + 32'd1;
  endfunction

endpackage

@@ design/cvds_coef.sv @@
module cvds_coef (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write_en,
  input  logic [cvds_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [cvds_pkg::CFG_DATA_W-1:0]    cfg_data,
  output cvds_pkg::coef_mat_t                coef
);
  import cvds_pkg::*;

  localparam int DIFF_W = COEF_W + 1;
  localparam int SCALE_W = DIFF_W + SEV_W + 1;
  localparam logic signed [SCALE_W-1:0] ROUND_HALF = SCALE_W'(128);

  cvd_type_t                  deficiency_type;
  cvd_type_t                  deficiency_type_next;
  logic [SEV_W-1:0]           severity;
  logic [SEV_W-1:0]           severity_next;
  logic [SEV_W-1:0]           sev_eff;
  logic signed [DIFF_W-1:0]   diff [MAT_ENTRIES];
  logic signed [SCALE_W-1:0]  scaled [MAT_ENTRIES];
  logic signed [SCALE_W-1:0]  rounded [MAT_ENTRIES];
  coef_mat_t                  coef_next;

  // Register write decode
  always_comb begin
    deficiency_type_next = deficiency_type;
    severity_next = severity;
    if (cfg_write_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_DEFICIENCY_TYPE: deficiency_type_next = cvd_type_t'(cfg_data[1:0]);
        REG_SEVERITY:        severity_next = cfg_data;
        default:             ;
      endcase
    end
  end

  // Blend identity toward the target: I + round((T - I) * s / 256)
  always_comb begin
    sev_eff = (severity_next > SEV_FULL) ? SEV_FULL : severity_next;
    for (int i = 0; i < MAT_ENTRIES; i++) begin
      diff[i] = DIFF_W'(TARGET_Q[deficiency_type_next][i]) - DIFF_W'(IDENT_MAT[i]);
      scaled[i] = SCALE_W'(diff[i]) * SCALE_W'($signed({1'b0, sev_eff}));
      rounded[i] = (scaled[i] + ROUND_HALF) >>> 8;
      coef_next[i] = coef_t'(IDENT_MAT[i] + coef_t'(rounded[i]));
    end
  end

  // Coefficients follow the registers in the same edge as the write
  always_ff @(posedge clk) begin
    if (rst) begin
      deficiency_type <= CVD_NORMAL;
      severity <= '0;
      coef <= IDENT_MAT;
    end else begin
      deficiency_type <= deficiency_type_next;
      severity <= severity_next;
      coef <= coef_next;
    end
  end

  a_reset_identity: assert property (@(posedge clk) rst |=> coef == IDENT_MAT)
    else $error("coefficients not identity after reset");

endmodule

@@ design/cvds_linearize.sv @@
module cvds_linearize #(
  parameter int LINEAR_FRAC_BITS = cvds_pkg::LINEAR_FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  cvds_pkg::pipe_ctl_t                    ctl,
  input  cvds_pkg::in_pixel_t                    pixel,
  output logic [2:0][LINEAR_FRAC_BITS:0]         lin
);
  import cvds_pkg::*;

  localparam int LinW = LINEAR_FRAC_BITS + 1;

  logic [LinW-1:0] rom [CODES];

  // Gamma 2.2 table, built at elaboration
  for (genvar g = 0; g < CODES; g++) begin : g_rom
    localparam logic [LinW-1:0] Entry = LinW'(lin_entry(LINEAR_FRAC_BITS, g));
    assign rom[g] = Entry;
  end

  // Stage A: linear values of the accepted pixel
  always_ff @(posedge clk) begin
    if (ctl.ld_lin) begin
      lin[0] <= rom[pixel.in_red];
      lin[1] <= rom[pixel.in_green];
      lin[2] <= rom[pixel.in_blue];
    end
  end

endmodule

@@ design/cvds_mix.sv @@
module cvds_mix #(
  parameter int LINEAR_FRAC_BITS = cvds_pkg::LINEAR_FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  cvds_pkg::pipe_ctl_t                    ctl,
  input  cvds_pkg::coef_mat_t                    coef,
  input  logic [2:0][LINEAR_FRAC_BITS:0]         lin,
  output logic [2:0][LINEAR_FRAC_BITS:0]         level
);
  import cvds_pkg::*;

  localparam int LinW = LINEAR_FRAC_BITS + 1;
  localparam int ProdW = COEF_W + LinW + 1;
  localparam int AccW = ProdW + 2;
  localparam logic [AccW-1:0] Top = AccW'(1) << (LINEAR_FRAC_BITS + COEF_FRAC);
  localparam logic [LinW-1:0] LinOne = LinW'(1) << LINEAR_FRAC_BITS;

  logic signed [ProdW-1:0] prod [CHANNELS][CHANNELS];
  logic signed [AccW-1:0]  acc [CHANNELS];
  logic [2:0][LinW-1:0]    level_next;

  // Stage B: nine products
  always_ff @(posedge clk) begin
    if (ctl.ld_prod) begin
      for (int r = 0; r < CHANNELS; r++) begin
        for (int c = 0; c < CHANNELS; c++) begin
          prod[r][c] <= $signed(coef[r * CHANNELS + c]) * $signed({1'b0, lin[c]});
        end
      end
    end
  end

  // Row sums, clamped to [0, 1] and dropped to linear precision
  always_comb begin
    for (int r = 0; r < CHANNELS; r++) begin
      acc[r] = AccW'(prod[r][0]) + AccW'(prod[r][1]) + AccW'(prod[r][2]);
      if (acc[r][AccW-1]) begin
        level_next[r] = '0;
      end else if (unsigned'(acc[r]) > Top) begin
        level_next[r] = LinOne;
      end else begin
        level_next[r] = acc[r][COEF_FRAC +: LinW];
      end
    end
  end

  // Stage C
  always_ff @(posedge clk) begin
    if (ctl.ld_sum) begin
      level <= level_next;
    end
  end

endmodule

@@ design/cvds_encode.sv @@
module cvds_encode #(
  parameter int LINEAR_FRAC_BITS = cvds_pkg::LINEAR_FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  cvds_pkg::pipe_ctl_t                    ctl,
  input  logic [2:0][LINEAR_FRAC_BITS:0]         level,
  output cvds_pkg::out_pixel_t                   pixel
);
  import cvds_pkg::*;

  localparam int LinW = LINEAR_FRAC_BITS + 1;

  logic [LinW-1:0]             rom [CODES];
  logic [2:0][CODES-1:0]       therm;
  logic [2:0][CODES-1:0]       therm_next;
  logic [2:0][CODE_W-1:0]      code;
  logic                        hit;

  for (genvar g = 0; g < CODES; g++) begin : g_rom
    localparam logic [LinW-1:0] Entry = LinW'(lin_entry(LINEAR_FRAC_BITS, g));
    assign rom[g] = Entry;
  end

  // Table is nondecreasing, so codes whose entry fits form a run from zero
  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      for (int k = 0; k < CODES; k++) begin
        therm_next[ch][k] = (rom[k] <= level[ch]);
      end
    end
  end

  // Stage D
  always_ff @(posedge clk) begin
    if (ctl.ld_therm) begin
      therm <= therm_next;
    end
  end

  // Top of the run gives the code
  always_comb begin
    hit = 1'b0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      code[ch] = '0;
      for (int k = 0; k < CODES; k++) begin
        if (k == CODES - 1) begin
          hit = therm[ch][k];
        end else begin
          hit = therm[ch][k] & ~therm[ch][k + 1];
        end
        code[ch] = code[ch] | (hit ? CODE_W'(k) : '0);
      end
    end
  end

  // Stage E: result register
  always_ff @(posedge clk) begin
    if (ctl.ld_out) begin
      pixel.out_red <= code[0];
      pixel.out_green <= code[1];
      pixel.out_blue <= code[2];
    end
  end

  a_therm_run: assert property (@(posedge clk) disable iff (rst)
    ctl.ld_out |-> ((((therm[0] >> 1) & ~therm[0]) | ((therm[1] >> 1) & ~therm[1])
                   | ((therm[2] >> 1) & ~therm[2])) == '0))
    else $error("threshold vector is not a run from code zero");

endmodule

@@ design/color_vision_deficiency_simulator.sv @@
// Color vision deficiency simulator, one sRGB pixel per transfer.
// Source channel: src_valid / src_ready / src_pixel; a transfer takes one pixel.
// Result channel: dst_valid / dst_ready / dst_pixel; one result per source pixel,
// in order.
// Configuration: cfg_write_en with cfg_index (0 deficiency type, 1 severity) and
// cfg_data; a write takes effect for pixels accepted at the same edge or later.
// Write only while no pixel is in flight.
// Pipeline: gamma table lookup, 3x3 products, row sum and clamp, threshold compare
// against the table, code encode. Throughput is one pixel per cycle while dst does
// not stall, set by the five-stage pipeline with one multiplier per coefficient.
// When dst stalls, stages fill behind the held result; src_ready drops only
// once all five stages hold a pixel. Bubbles are squeezed out.
// Reset empties the pipeline, sets normal vision and severity zero (identity).
module color_vision_deficiency_simulator #(
  parameter int LINEAR_FRAC_BITS = cvds_pkg::LINEAR_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write_en,
  input  logic [cvds_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [cvds_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               src_valid,
  output logic                               src_ready,
  input  cvds_pkg::in_pixel_t                src_pixel,
  output logic                               dst_valid,
  input  logic                               dst_ready,
  output cvds_pkg::out_pixel_t               dst_pixel
);
  import cvds_pkg::*;

  localparam int LinW = LINEAR_FRAC_BITS + 1;

  pipe_ctl_t             ctl;
  coef_mat_t             coef;
  logic [2:0][LinW-1:0]  lin;
  logic [2:0][LinW-1:0]  level;
  logic                  v_lin;
  logic                  v_prod;
  logic                  v_sum;
  logic                  v_therm;
  logic                  rdy_out;
  logic                  rdy_therm;
  logic                  rdy_sum;
  logic                  rdy_prod;

  // A stage can load when empty or when its item moves on
  always_comb begin
    rdy_out = !dst_valid || dst_ready;
    rdy_therm = !v_therm || rdy_out;
    rdy_sum = !v_sum || rdy_therm;
    rdy_prod = !v_prod || rdy_sum;
    src_ready = !v_lin || rdy_prod;
    ctl.ld_lin = src_valid && src_ready;
    ctl.ld_prod = v_lin && rdy_prod;
    ctl.ld_sum = v_prod && rdy_sum;
    ctl.ld_therm = v_sum && rdy_therm;
    ctl.ld_out = v_therm && rdy_out;
  end

  // Stage occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      v_lin <= 1'b0;
      v_prod <= 1'b0;
      v_sum <= 1'b0;
      v_therm <= 1'b0;
      dst_valid <= 1'b0;
    end else begin
      v_lin <= ctl.ld_lin || (v_lin && !ctl.ld_prod);
      v_prod <= ctl.ld_prod || (v_prod && !ctl.ld_sum);
      v_sum <= ctl.ld_sum || (v_sum && !ctl.ld_therm);
      v_therm <= ctl.ld_therm || (v_therm && !ctl.ld_out);
      dst_valid <= ctl.ld_out || (dst_valid && !dst_ready);
    end
  end

  cvds_coef u_coef (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .coef         (coef)
  );

  cvds_linearize #(.LINEAR_FRAC_BITS(LINEAR_FRAC_BITS)) u_linearize (
    .clk   (clk),
    .ctl   (ctl),
    .pixel (src_pixel),
    .lin   (lin)
  );

  cvds_mix #(.LINEAR_FRAC_BITS(LINEAR_FRAC_BITS)) u_mix (
    .clk   (clk),
    .ctl   (ctl),
    .coef  (coef),
    .lin   (lin),
    .level (level)
  );

  cvds_encode #(.LINEAR_FRAC_BITS(LINEAR_FRAC_BITS)) u_encode (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .level (level),
    .pixel (dst_pixel)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    v_prod && !ctl.ld_sum |-> !ctl.ld_prod)
    else $error("product stage overwritten while held");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    v_lin && v_prod && v_sum && v_therm && dst_valid && !dst_ready |-> !src_ready)
    else $error("pixel accepted into a full stalled pipeline");

  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    v_sum && !ctl.ld_therm |=> v_sum)
    else $error("sum stage dropped a pixel");

  a_reset_empty: assert property (@(posedge clk) rst |=> !dst_valid && src_ready)
    else $error("pipeline not empty after reset");

endmodule

@@ tb/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cvds_pkg::*;

  localparam int GAMMA_FRAC = LINEAR_FRAC_BITS_DEF;
  localparam int UNITY = 1 << COEF_FRAC;
  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT = 2000;
  localparam int SEV_MAX = (1 << SEV_W) - 1;

  // Full dichromat mixing matrices, row major, Q2.14 (normal, protan, deutan, tritan)
  localparam int DICHROMAT_Q [4][9] = '{
    '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384},
    '{2495, 17246, -3357, 1876, 12882, 1626, -64, -788, 17236},
    '{6018, 14101, -3735, 4589, 11018, 777, -194, 704, 15874},
    '{20571, -1257, -2929, -1285, 15250, 2418, 78, 11327, 4979}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic src_valid = 1'b0;
  logic src_ready;
  in_pixel_t src_pixel = '0;
  logic dst_valid;
  logic dst_ready = 1'b0;
  out_pixel_t dst_pixel;

  // Predictor state
  int unsigned gamma_lin [CODES];
  cvd_type_t model_type = CVD_NORMAL;
  logic [SEV_W-1:0] model_sev = '0;
  out_pixel_t expected_pixels [$];

  int src_idle_pct = 25;
  int dst_stall_pct = 74;
  int errors = 0;
  int quiet_cycles = 0;
  out_pixel_t want;

  color_vision_deficiency_simulator dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .src_valid    (src_valid),
    .src_ready    (src_ready),
    .src_pixel    (src_pixel),
    .dst_valid    (dst_valid),
    .dst_ready    (dst_ready),
    .dst_pixel    (dst_pixel)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // True when level / 2^F >= (code / 255)^2.2, decided on exact integers
  function automatic bit reaches(int unsigned level, int code);
    logic [255:0] lhs;
    logic [255:0] rhs;
    lhs = 256'd1;
    rhs = 256'd1;
    for (int i = 0; i < 5; i++) lhs = lhs * 256'(level);
    for (int i = 0; i < 11; i++) lhs = lhs * 256'd255;
    for (int i = 0; i < 11; i++) rhs = rhs * 256'(code);
    rhs = rhs << (5 * GAMMA_FRAC);
    return lhs >= rhs;
  endfunction

  // Gamma table: start from a float guess, then settle on the exact ceiling
  initial begin : build_gamma
    int unsigned level;
    for (int c = 0; c < CODES; c++) begin
      level = $rtoi($ceil((2.0 ** GAMMA_FRAC) * ((c / 255.0) ** 2.2)));
      while (level > 0 && reaches(level - 1, c)) level--;
      while (!reaches(level, c)) level++;
      gamma_lin[c] = level;
    end
  end

  // Simulated pixel for the current deficiency type and severity
  function automatic out_pixel_t predict_pixel(in_pixel_t px);
    int sev;
    int coef [9];
    longint lin [3];
    longint acc;
    longint top;
    int k;
    logic [CODE_W-1:0] codes [3];
    sev = (model_sev > SEV_FULL) ? int'(SEV_FULL) : int'(model_sev);
    top = longint'(1) << (GAMMA_FRAC + COEF_FRAC);
    for (int i = 0; i < 9; i++) begin
      coef[i] = ((i % 4 == 0) ? UNITY : 0)
              + ((((DICHROMAT_Q[int'(model_type)][i] - ((i % 4 == 0) ? UNITY : 0)) * sev)
                 + 128) >>> 8);
    end
    lin[0] = longint'(gamma_lin[px.in_red]);
    lin[1] = longint'(gamma_lin[px.in_green]);
    lin[2] = longint'(gamma_lin[px.in_blue]);
    for (int r = 0; r < 3; r++) begin
      acc = longint'(coef[3*r]) * lin[0] + longint'(coef[3*r+1]) * lin[1]
          + longint'(coef[3*r+2]) * lin[2];
      if (acc < 0) acc = 0;
      if (acc > top) acc = top;
      // largest code whose table level does not exceed the mix
      k = CODES - 1;
      while (k > 0 && (longint'(gamma_lin[k]) << COEF_FRAC) > acc) k--;
      codes[r] = k[CODE_W-1:0];
    end
    return {codes[0], codes[1], codes[2]};
  endfunction

  // Source side: optional idle, then hold the pixel until the transfer
  task automatic send_pixel(in_pixel_t px);
    while ($urandom_range(99) < src_idle_pct) begin
      src_valid <= 1'b0;
      @(posedge clk);
    end
    src_valid <= 1'b1;
    src_pixel <= px;
    @(posedge clk);
    while (!src_ready) @(posedge clk);
    expected_pixels = {expected_pixels, predict_pixel(px)};
  endtask

  // Stop sending and wait until every result is back and the pipe is quiet
  task automatic drain_pipeline();
    src_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    case (idx)
      REG_DEFICIENCY_TYPE: model_type = cvd_type_t'(data[1:0]);
      REG_SEVERITY:        model_sev = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic reconfigure(cvd_type_t kind, logic [SEV_W-1:0] sev);
    drain_pipeline();
    cfg_write(REG_DEFICIENCY_TYPE, CFG_DATA_W'(kind));
    cfg_write(REG_SEVERITY, sev);
  endtask

  function automatic logic [CODE_W-1:0] random_code();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return CODE_W'($urandom_range(CODES - 1));
    endcase
  endfunction

  function automatic logic [SEV_W-1:0] random_severity();
    case ($urandom_range(5))
      0: return '0;
      1: return SEV_FULL;
      2: return SEV_W'($urandom_range(SEV_MAX, int'(SEV_FULL) + 1));
      default: return SEV_W'($urandom_range(int'(SEV_FULL) - 1, 1));
    endcase
  endfunction

  // Identity path: corners, primaries, the lowest codes and one mid-range pixel
  task automatic test_identity();
    reconfigure(CVD_NORMAL, '0);
    send_pixel({8'd0, 8'd0, 8'd0});
    send_pixel({8'd255, 8'd255, 8'd255});
    send_pixel({8'd255, 8'd0, 8'd0});
    send_pixel({8'd0, 8'd255, 8'd0});
    send_pixel({8'd0, 8'd0, 8'd255});
    send_pixel({8'd1, 8'd2, 8'd3});
    send_pixel({8'd128, 8'd64, 8'd32});
  endtask

  // Full severity for every type: white overflows on tritan, pure blue goes negative
  task automatic test_full_dichromacy();
    for (int t = 0; t < 4; t++) begin
      reconfigure(cvd_type_t'(t), SEV_FULL);
      send_pixel({8'd255, 8'd255, 8'd255});
      send_pixel({8'd0, 8'd0, 8'd255});
      send_pixel({8'd255, 8'd0, 8'd0});
    end
  endtask

  // Severity above full saturates; half severity blends
  task automatic test_severity_saturation();
    reconfigure(CVD_PROTAN, SEV_W'(SEV_MAX));
    send_pixel({8'd200, 8'd40, 8'd180});
    reconfigure(CVD_PROTAN, SEV_W'(int'(SEV_FULL) + 1));
    send_pixel({8'd200, 8'd40, 8'd180});
    reconfigure(CVD_DEUTAN, 9'd128);
    send_pixel({8'd200, 8'd40, 8'd180});
  endtask

  // Random pixels, new random settings every hundred, one plain pause midway
  task automatic test_random_stream(int src_pct, int dst_pct, int count);
    src_idle_pct = src_pct;
    dst_stall_pct = dst_pct;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0)
        reconfigure(cvd_type_t'($urandom_range(3)), random_severity());
      else if (i == count / 2)
        drain_pipeline();
      send_pixel({random_code(), random_code(), random_code()});
    end
  endtask

  // Result side stalls
  always @(posedge clk) dst_ready <= ($urandom_range(99) >= dst_stall_pct);

  task automatic check_channel(string name, logic [CODE_W-1:0] exp_v, logic [CODE_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    if (!rst && dst_valid && dst_ready) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: result with nothing expected: expected none, actual %h",
                 $time, dst_pixel);
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        check_channel("out_red", want.out_red, dst_pixel.out_red);
        check_channel("out_green", want.out_green, dst_pixel.out_green);
        check_channel("out_blue", want.out_blue, dst_pixel.out_blue);
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (src_valid && src_ready) || (dst_valid && dst_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_identity();
    test_full_dichromacy();
    test_severity_saturation();
    test_random_stream(25, 74, 620);
    test_random_stream(74, 25, 620);
    test_random_stream(0, 0, 610);
    drain_pipeline();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/cvds_pkg.sv
design/cvds_coef.sv
design/cvds_linearize.sv
design/cvds_mix.sv
design/cvds_encode.sv
design/color_vision_deficiency_simulator.sv
tb/testbench.sv
